// ===== src/npcc_pkg.sv =====
// Shared types, constants and helpers of the nearest-prototype color classifier.
package npcc_pkg;

    // Default table depth.
    localparam int MAX_ENTRIES_DEF = 64;

    // Field widths fixed by the item formats.
    localparam int CH_W      = 8;
    localparam int LAB_W     = 3;
    localparam int IN_IDX_W  = 6;
    localparam int OUT_IDX_W = 6;
    localparam int DIST_W    = 18;
    localparam int SQ_W      = 2 * CH_W;
    localparam int CNT_CFG_W = 7;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_BIT = 2;

    // Item kinds.
    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    // Register indexes, selected by one address bit.
    localparam logic REG_ENTRY_COUNT    = 1'b0;
    localparam logic REG_NO_MATCH_BOUND = 1'b1;

    // Register reset values.
    localparam logic [CNT_CFG_W-1:0] ENTRY_COUNT_RST = 7'd49;
    localparam logic [DIST_W-1:0]    BOUND_RST       = 18'd85025;

    typedef struct packed {
        logic                 kind;
        logic [IN_IDX_W-1:0]  entry_index;
        logic [CH_W-1:0]      chan_l;
        logic [CH_W-1:0]      chan_a;
        logic [CH_W-1:0]      chan_b;
        logic [LAB_W-1:0]     entry_label;
    } item_t;

    typedef struct packed {
        logic [LAB_W-1:0]     label;
        logic [OUT_IDX_W-1:0] best_index;
        logic [DIST_W-1:0]    best_distance;
        logic                 matched;
    } result_t;

    typedef struct packed {
        logic [CH_W-1:0] l;
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
    } chan_t;

    // One table entry: 27 bits.
    typedef struct packed {
        logic [LAB_W-1:0] lab;
        chan_t            ch;
    } entry_t;

    // Square of the absolute difference of two channel values.
    function automatic logic [SQ_W-1:0] sq_diff(input logic [CH_W-1:0] p,
                                                 input logic [CH_W-1:0] q);
        logic [CH_W-1:0] d;
        d = (p >= q) ? (p - q) : (q - p);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

// ===== src/npcc_dist.sv =====
// Pipelined squared-distance unit: registered channel squares, summed at the output.
module npcc_dist (
    input  logic                  clk,
    input  logic                  en,
    input  npcc_pkg::chan_t       pix,
    input  npcc_pkg::chan_t       proto,
    output logic [npcc_pkg::DIST_W-1:0] dist_sum
);
    import npcc_pkg::*;

    logic [SQ_W-1:0] sq_l_reg;
    logic [SQ_W-1:0] sq_a_reg;
    logic [SQ_W-1:0] sq_b_reg;

    // One 8x8 square per channel, registered.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_l_reg <= sq_diff(proto.l, pix.l);
            sq_a_reg <= sq_diff(proto.a, pix.a);
            sq_b_reg <= sq_diff(proto.b, pix.b);
        end
    end

    // The sum of three squares fits in 18 bits.
    assign dist_sum = DIST_W'(sq_l_reg) + DIST_W'(sq_a_reg) + DIST_W'(sq_b_reg);

endmodule

// ===== src/nearest_prototype_color_classifier_top.sv =====
// Top level of the nearest-prototype color classifier.
//
// Input channel (item_valid, item_stall, item): a load item writes one prototype
// entry and gives no result; a load whose index is beyond the
// table is dropped. A classify item walks entries 0 .. entry_count-1 of the
// table memory, one entry per cycle through its single read port, and gives one
// result item on (result_valid, result_stall, result).
// The entry count is clipped to the table. A classify item holds the input
// stalled while the search runs; the result item is loaded into the output
// register at the edge that ends the stall, and the next item can be taken
// after that edge. The read port sets the pace of the search.
// The result sits in an output register: while the receiver stalls it holds
// steady, and the block still takes load items; a following classify finishes
// its search and then waits until the register is free.
// Configuration registers sit on an APB port: entry_count at address 0 and
// no_match_bound at address 4. Write them only while the block is idle.
// Reset clears the control state and the registers (entry_count 49,
// no_match_bound 85025). The table memory is not cleared: load every entry
// before a classify reaches it.
module nearest_prototype_color_classifier_top #(
    parameter int MAX_ENTRIES = npcc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [npcc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [npcc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [npcc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  npcc_pkg::item_t                   item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output npcc_pkg::result_t                 result
);
    import npcc_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Configuration registers.
    logic [CNT_CFG_W-1:0] entry_count_reg;
    logic [DIST_W-1:0]    bound_reg;

    // Sequencer.
    logic [1:0]       state_reg;
    logic             issue_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             rd_v_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             sq_v_reg;
    logic [IDX_W-1:0] sq_idx_reg;
    logic             sq_use_reg;
    logic [LAB_W-1:0] sq_lab_reg;

    // Search context and running minimum.
    chan_t            pix_reg;
    logic [CNT_W-1:0] n_reg;
    logic [IDX_W-1:0] last_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [LAB_W-1:0] best_lab_reg;
    logic [LAB_W-1:0] lab0_reg;
    logic             hit_reg;

    // Output register.
    logic    result_valid_reg;
    result_t result_reg;

    // Table memory and its registered read data.
    entry_t mem [MAX_ENTRIES];
    entry_t rd_q_reg;

    logic             cfg_wr;
    logic             item_acc;
    logic             load_wr;
    logic             classify_start;
    logic [CNT_W-1:0] n_sat;
    logic [IDX_W-1:0] last_sat;
    logic [DIST_W-1:0] sq_dist;
    logic             done;
    logic             slot_free;
    logic             better;

    // Configuration port: always ready, one address bit picks the register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RST;
            bound_reg       <= BOUND_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[REG_SEL_BIT])
                REG_ENTRY_COUNT:    entry_count_reg <= pwdata[CNT_CFG_W-1:0];
                REG_NO_MATCH_BOUND: bound_reg       <= pwdata[DIST_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[REG_SEL_BIT])
            REG_ENTRY_COUNT:    prdata = APB_DATA_W'(entry_count_reg);
            REG_NO_MATCH_BOUND: prdata = APB_DATA_W'(bound_reg);
            default:            prdata = '0;
        endcase
    end

    // Input handshake: items are taken only while the sequencer is idle.
    assign item_stall     = (state_reg != ST_IDLE);
    assign item_acc       = item_valid && !item_stall;
    assign load_wr        = item_acc && (item.kind == KIND_LOAD) &&
                            (int'(item.entry_index) < MAX_ENTRIES);
    assign classify_start = item_acc && (item.kind == KIND_CLASSIFY);

    // Entry count clipped to the table; at least entry 0 is always read.
    always_comb
    begin
        if (int'(entry_count_reg) > MAX_ENTRIES)
        begin
            n_sat = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            n_sat = CNT_W'(entry_count_reg);
        end
        last_sat = (n_sat == '0) ? '0 : IDX_W'(n_sat - 1'b1);
    end

    // Table memory: one write port for loads, one read port for the search.
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            mem[IDX_W'(item.entry_index)] <= '{lab: item.entry_label,
                                               ch: '{l: item.chan_l,
                                                     a: item.chan_a,
                                                     b: item.chan_b}};
        end
        if (issue_reg)
        begin
            rd_q_reg <= mem[rd_addr_reg];
        end
    end

    // Distance stage.
    npcc_dist u_dist (
        .clk      (clk),
        .en       (rd_v_reg),
        .pix      (pix_reg),
        .proto    (rd_q_reg.ch),
        .dist_sum (sq_dist)
    );

    assign done      = sq_v_reg && (sq_idx_reg == last_reg);
    assign slot_free = !result_valid_reg || !result_stall;
    assign better    = sq_v_reg && sq_use_reg && (sq_dist < best_dist_reg);

    // Sequencer control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            issue_reg        <= 1'b0;
            rd_addr_reg      <= '0;
            rd_v_reg         <= 1'b0;
            sq_v_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= issue_reg;
            sq_v_reg <= rd_v_reg;

            // Read address walk.
            if (classify_start)
            begin
                issue_reg   <= 1'b1;
                rd_addr_reg <= '0;
            end
            else if (issue_reg)
            begin
                if (rd_addr_reg == last_reg)
                begin
                    issue_reg <= 1'b0;
                end
                else
                begin
                    rd_addr_reg <= rd_addr_reg + 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (classify_start)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (done)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Output register valid.
            if ((state_reg == ST_DONE) && slot_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Search datapath: pipeline tags, running minimum and result.
    always_ff @(posedge clk)
    begin
        if (classify_start)
        begin
            pix_reg       <= '{l: item.chan_l, a: item.chan_a, b: item.chan_b};
            n_reg         <= n_sat;
            last_reg      <= last_sat;
            best_dist_reg <= bound_reg;
            best_idx_reg  <= '0;
            hit_reg       <= 1'b0;
        end
        else if (better)
        begin
            best_dist_reg <= sq_dist;
            best_idx_reg  <= sq_idx_reg;
            best_lab_reg  <= sq_lab_reg;
            hit_reg       <= 1'b1;
        end

        rd_idx_reg <= rd_addr_reg;
        sq_idx_reg <= rd_idx_reg;
        sq_use_reg <= (CNT_W'(rd_idx_reg) < n_reg);
        sq_lab_reg <= rd_q_reg.lab;

        // Entry 0 supplies the label when nothing beats the bound.
        if (rd_v_reg && (rd_idx_reg == '0))
        begin
            lab0_reg <= rd_q_reg.lab;
        end

        if ((state_reg == ST_DONE) && slot_free)
        begin
            result_reg <= '{label:         hit_reg ? best_lab_reg : lab0_reg,
                            best_index:    OUT_IDX_W'(best_idx_reg),
                            best_distance: best_dist_reg,
                            matched:       hit_reg};
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== src/npcc_checker.sv =====
// Port-level checker for the classifier top level, with its bind statement.
module npcc_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input npcc_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input npcc_pkg::result_t result
);
    import npcc_pkg::*;

    // A stalled result item stays and holds its value.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result item dropped or changed while stalled");

    // An unmatched result reports index 0.
    a_unmatched_index: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.matched |-> result.best_index == '0)
        else $error("unmatched result with nonzero index");

    // A classify item occupies the block on the following cycle.
    a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.kind == KIND_CLASSIFY) |=> item_stall)
        else $error("classify item did not start a search");

    // A load item completes in its own cycle.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && (item.kind == KIND_LOAD) |=> !item_stall)
        else $error("load item stalled the input");

endmodule

bind nearest_prototype_color_classifier_top npcc_checker u_npcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
